@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the mfmc_core RTL module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, masked while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Invariant checked on every rising edge, masked while in reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

@@ hdl/mfmc_pkg.sv @@
// ----------------------------------------------------------------------------
// mfmc_pkg
// Types and constants for the MFM bit-cell codec with sync detection.
// ----------------------------------------------------------------------------
package mfmc_pkg;

    localparam logic [15:0] SYNC_RAW_A1  = 16'h4489;
    localparam logic [15:0] SYNC_RAW_C2  = 16'h5224;
    localparam logic [7:0]  SYNC_BYTE_A1 = 8'hA1;
    localparam logic [7:0]  SYNC_BYTE_C2 = 8'hC2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic       sync_flag;
        logic [7:0] write_byte;
        logic       index_mark;
        logic       disk_bit;
        logic       mode;
    } t_item;

    typedef struct packed {
        logic reading;
        logic on_index;
        logic sync_seen;
        logic cell_value;
        logic wrote_cell;
    } t_result;

endpackage

@@ hdl/mfmc_in_stage.sv @@
// ----------------------------------------------------------------------------
// mfmc_in_stage
// Input register: holds one request until the cell engine takes it.
// ----------------------------------------------------------------------------
module mfmc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mfmc_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output mfmc_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    mfmc_pkg::t_item r_item;
    logic            w_load;

    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/mfmc_core.sv @@
// ----------------------------------------------------------------------------
// mfmc_core
// Cell engine state and result register: read shift/sync detect, byte load,
// MFM or raw sync cell write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfmc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_take,
    input  mfmc_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output mfmc_pkg::t_result o_result
);

    logic [15:0]       r_shift,   n_shift;
    logic [15:0]       r_pending, n_pending;
    logic              r_raw,     n_raw;
    logic [3:0]        r_pos,     n_pos;
    logic              r_read,    n_read;
    logic              r_sync,    n_sync;
    logic              r_index,   n_index;
    logic              r_out_valid;
    mfmc_pkg::t_result r_out,     n_out;
    logic              w_cell;
    logic              w_data;

    assign o_take = i_valid && (!r_out_valid || i_ready);

    // next cell to write
    always_comb begin
        w_data = r_pending[{1'b0, ~r_pos[3:1]}];
        if (r_raw) begin
            w_cell = r_pending[~r_pos];
        end else if (r_pos[0]) begin
            w_cell = w_data;
        end else begin
            w_cell = !w_data && !r_shift[0];
        end
    end

    always_comb begin
        n_shift   = r_shift;
        n_pending = r_pending;
        n_raw     = r_raw;
        n_pos     = r_pos;
        n_read    = r_read;
        n_sync    = r_sync;
        n_index   = r_index;
        n_out.wrote_cell = 1'b0;
        if (i_item.mode) begin
            n_read = 1'b0;
            n_pos  = '0;
            if (i_item.sync_flag && i_item.write_byte == mfmc_pkg::SYNC_BYTE_A1) begin
                n_raw     = 1'b1;
                n_pending = mfmc_pkg::SYNC_RAW_A1;
            end else if (i_item.sync_flag && i_item.write_byte == mfmc_pkg::SYNC_BYTE_C2) begin
                n_raw     = 1'b1;
                n_pending = mfmc_pkg::SYNC_RAW_C2;
            end else begin
                n_raw     = 1'b0;
                n_pending = {8'h00, i_item.write_byte};
            end
        end else if (r_read) begin
            n_shift = {r_shift[14:0], i_item.disk_bit};
            n_index = i_item.index_mark;
            n_sync  = (n_shift == mfmc_pkg::SYNC_RAW_A1) || (n_shift == mfmc_pkg::SYNC_RAW_C2);
        end else begin
            n_shift = {r_shift[14:0], w_cell};
            n_pos   = r_pos + 4'd1;
            n_read  = (r_pos == 4'd15);
            n_out.wrote_cell = 1'b1;
        end
        n_out.cell_value = n_shift[0];
        n_out.sync_seen  = n_sync;
        n_out.on_index   = n_index;
        n_out.reading    = n_read;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_pending   <= '0;
            r_raw       <= 1'b0;
            r_pos       <= '0;
            r_read      <= 1'b1;
            r_sync      <= 1'b0;
            r_index     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_shift   <= n_shift;
                r_pending <= n_pending;
                r_raw     <= n_raw;
                r_pos     <= n_pos;
                r_read    <= n_read;
                r_sync    <= n_sync;
                r_index   <= n_index;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `ASSERT_CLK(a_load_starts_write, i_clk, i_rst_n, (o_take && i_item.mode) |=> (!r_read && r_pos == 4'd0), "load did not start a write at cell 0")
    `ASSERT_CLK(a_last_cell_reads, i_clk, i_rst_n, (o_take && !i_item.mode && !r_read && r_pos == 4'd15) |=> r_read, "engine did not return to reading after 16 cells")
    `ASSERT_ALWAYS(a_raw_is_sync, i_clk, i_rst_n, (!r_raw || r_pending == mfmc_pkg::SYNC_RAW_A1 || r_pending == mfmc_pkg::SYNC_RAW_C2), "raw write word is not a sync pattern")
    `ASSERT_CLK(a_read_keeps_pos, i_clk, i_rst_n, (o_take && !i_item.mode && r_read) |=> (r_pos == $past(r_pos) && !o_result.wrote_cell), "read tick moved write position")

endmodule

@@ hdl/mfm_bit_cell_codec_sync_unit.sv @@
// ----------------------------------------------------------------------------
// mfm_bit_cell_codec_sync_unit
// Floppy MFM bit-cell engine: reads cells with sync/index detection and
// writes bytes as MFM cells or raw A1/C2 sync patterns.
// ----------------------------------------------------------------------------
// channel  | dir | content
// s_axis   | in  | one request per cell tick or byte load (tuser = load)
// m_axis   | out | one result per request
//
// One request per cycle sustained while m_axis_tready stays high. A request
// accepted on s_axis is held in the input register until the cell engine takes
// it; the engine registers its result in the result register for m_axis.
// The cell engine updates its state once for each request it takes.
// Reset (i_rst_n low, synchronous) puts the engine in read mode, other state registers 0.
// A stalled output holds its result; the input register takes one more
// request, then s_axis_tready stays low until the result is taken.
// ----------------------------------------------------------------------------
module mfm_bit_cell_codec_sync_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] disk_bit, [1] index_mark, [9:2] write_byte, [10] sync_flag
    input  logic [mfmc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] wrote_cell, [1] cell_value, [2] sync_seen, [3] on_index, [4] reading
    output logic [mfmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    mfmc_pkg::t_item   w_in_item;
    mfmc_pkg::t_item   w_stage_item;
    mfmc_pkg::t_result w_result;
    logic              w_stage_valid;
    logic              w_take;

    assign w_in_item.mode       = s_axis_tuser;
    assign w_in_item.disk_bit   = s_axis_tdata[0];
    assign w_in_item.index_mark = s_axis_tdata[1];
    assign w_in_item.write_byte = s_axis_tdata[9:2];
    assign w_in_item.sync_flag  = s_axis_tdata[10];

    mfmc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_stage_valid),
        .i_take  (w_take),
        .o_item  (w_stage_item)
    );

    mfmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_stage_valid),
        .o_take   (w_take),
        .i_item   (w_stage_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {3'b000, w_result.reading, w_result.on_index, w_result.sync_seen,
                           w_result.cell_value, w_result.wrote_cell};

endmodule
